// ===== src/cksum_pkg.sv =====
// Shared types, constants, the byte-wise CRC-32 function and the modulo-65521 add for the checksum engine.
package cksum_pkg;

	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [16:0] ADLER_MOD    = 17'd65521;
	localparam int unsigned ADLER_SHIFT  = 16;

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ALGORITHM      = 2'd0,
		CFG_EXPECTED_VALUE = 2'd1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ALG_CRC32   = 2'd0,
		ALG_ADLER32 = 2'd1,
		ALG_XOR8    = 2'd2,
		ALG_SUM32   = 2'd3
	} alg_t;

	// One word moving from the input register into the accumulators.
	typedef struct packed {
		logic       step;
		logic       last;
		logic [7:0] data;
	} accum_ctrl_t;

	// Reflected CRC-32 over one byte, eight shift steps.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Add modulo 65521; both operands already reduced, so one subtract suffices.
	function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= ADLER_MOD) begin
			s = s - ADLER_MOD;
		end
		return s[15:0];
	endfunction

endpackage

// ===== src/cksum_accum.sv =====
// Running checksum registers and finished-result selection for the checksum engine.
module cksum_accum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cksum_pkg::accum_ctrl_t    ctrl,
	input  cksum_pkg::alg_t           alg,
	input  logic [31:0]               expected_value,
	output logic [31:0]               checksum,
	output logic                      matches_res
);
	import cksum_pkg::*;

	logic [31:0] crc_q;
	logic [15:0] adler_lo_q;
	logic [15:0] adler_hi_q;
	logic [7:0]  xor_q;
	logic [31:0] sum_q;

	logic [31:0] crc_nxt;
	logic [15:0] adler_lo_nxt;
	logic [15:0] adler_hi_nxt;
	logic [7:0]  xor_nxt;
	logic [31:0] sum_nxt;

	always_comb begin
		crc_nxt      = crc32_byte(crc_q, ctrl.data);
		adler_lo_nxt = adler_add(adler_lo_q, {8'd0, ctrl.data});
		adler_hi_nxt = adler_add(adler_hi_q, adler_lo_nxt);
		xor_nxt      = xor_q ^ ctrl.data;
		sum_nxt      = sum_q + {24'd0, ctrl.data};
	end

	always_comb begin
		case (alg)
			ALG_CRC32:   checksum = crc_nxt ^ CRC_ALL_ONES;
			ALG_ADLER32: checksum = {adler_hi_nxt, adler_lo_nxt};
			ALG_XOR8:    checksum = {24'd0, xor_nxt};
			ALG_SUM32:   checksum = sum_nxt;
			default:     checksum = sum_nxt;
		endcase
		matches_res = (checksum == expected_value);
	end

	// Advance all four sums on every word; restart them after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_ALL_ONES;
			adler_lo_q <= 16'd1;
			adler_hi_q <= 16'd0;
			xor_q      <= 8'd0;
			sum_q      <= 32'd0;
		end else if (ctrl.step) begin
			if (ctrl.last) begin
				crc_q      <= CRC_ALL_ONES;
				adler_lo_q <= 16'd1;
				adler_hi_q <= 16'd0;
				xor_q      <= 8'd0;
				sum_q      <= 32'd0;
			end else begin
				crc_q      <= crc_nxt;
				adler_lo_q <= adler_lo_nxt;
				adler_hi_q <= adler_hi_nxt;
				xor_q      <= xor_nxt;
				sum_q      <= sum_nxt;
			end
		end
	end

endmodule

// ===== src/multi_algorithm_checksum_engine_core.sv =====
// Top level of the multi-algorithm checksum engine: input register, accumulators, result register.
//
// Usage:
//   Stream a region's bytes in on the s_ group, one byte per word, with s_tlast
//   high on the final byte. Every word advances CRC-32, Adler-32, XOR-8 and the
//   32-bit byte sum together. On the last byte one word leaves on the m_ group:
//   m_tdata holds the checksum picked by the algorithm register, m_tuser says
//   whether it equals the expected value. Other bytes produce no output word.
//   Configuration goes in over the cfg_ channel (index 0 algorithm, index 1
//   expected value); cfg_ready is always high, out-of-range indexes are dropped.
//   Write configuration only while no region is in flight.
// Timing:
//   One byte per clock sustained unless a last byte waits on a busy result slot. A last
//   byte goes from the input register into the result register, which drives m_tvalid.
//   Byte CRC (eight shift steps) plus the Adler add/compare sets the clock path.
// Reset:
//   arst_n clears both registers' valid flags, sets algorithm to CRC-32 and
//   expected value to zero, and restarts all sums at their initial values.
// Stall:
//   When m_tready is low and a result waits, the input register still drains
//   non-last bytes; a last byte holds there and s_tready drops until it moves.
module multi_algorithm_checksum_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tlast,   // last_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,   // [31:0] checksum
	output logic                           m_tuser,   // [0] matches_res
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cksum_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import cksum_pkg::*;

	alg_t        alg_q;
	logic [31:0] expected_q;

	logic        vld_s1;
	logic        last_s1;
	logic [7:0]  data_s1;

	logic        out_vld_q;
	logic [31:0] checksum_q;
	logic        match_q;

	logic        out_free;
	logic        advance;
	accum_ctrl_t ctrl;
	logic [31:0] checksum_c;
	logic        match_c;

	assign cfg_ready = 1'b1;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q      <= ALG_CRC32;
			expected_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ALGORITHM:      alg_q      <= alg_t'(cfg_data[1:0]);
				CFG_EXPECTED_VALUE: expected_q <= cfg_data;
				default:            ;
			endcase
		end
	end

	// A byte leaves the input register unless it is last and the result slot is busy.
	assign out_free = !out_vld_q || m_tready;
	assign advance  = vld_s1 && (!last_s1 || out_free);
	assign s_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign ctrl.step = advance;
	assign ctrl.last = last_s1;
	assign ctrl.data = data_s1;

	cksum_accum u_accum (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.alg            (alg_q),
		.expected_value (expected_q),
		.checksum       (checksum_c),
		.matches_res    (match_c)
	);

	// Result register: load on a last byte, hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			checksum_q <= checksum_c;
			match_q    <= match_c;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = checksum_q;
	assign m_tuser  = match_q;

endmodule
